@@ hw/rtl/bba_pkg.sv @@
// Shared types, constants and the helper function of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  // Payload widths of the request and result transactions.
  localparam int ID_W     = 10;
  localparam int STATUS_W = 2;

  // Configuration register widths and layout.
  localparam int           BC_W         = 11;
  localparam int           CFG_DATA_W   = 32;
  localparam int           CFG_ADDR_W   = 3;
  localparam logic         REG_BLOCK_COUNT = 1'b0;
  localparam logic [BC_W-1:0] BC_RESET  = 11'd1024;

  // Bitmap memory word geometry.
  localparam int WORD_W      = 32;
  localparam int WORD_BITS_W = 5;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESP
  } state_t;

  // Index of the lowest set bit of a word; zero when no bit is set.
  function automatic logic [WORD_BITS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_BITS_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_BITS_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bba_req_if.sv @@
// Request channel interface: allocate or free transactions.
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] block_id;

  modport source (output valid, output kind, output block_id, input ready);
  modport sink   (input valid, input kind, input block_id, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bba_rsp_if.sv @@
// Result channel interface: status and granted block id.
`default_nettype none

interface bba_rsp_if import bba_pkg::*; ();
  logic            valid;
  logic            ready;
  status_t         status;
  logic [ID_W-1:0] granted_id;

  modport source (output valid, output status, output granted_id, input ready);
  modport sink   (input valid, input status, input granted_id, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bba_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_block_allocator_top.sv @@
// Top level of the bitmap block allocator: sequencer, bitmap memory and register port.
//
//   Channel   Role                    Transaction fields
//   in_ch     request sink            kind, block_id
//   out_ch    result source           status, granted_id
//   cfg_*     APB register port       block_count at byte address 0
//
// An allocate scans the 32-bit bitmap words, one word per cycle through the single
// read port of the bitmap memory, until a free bit turns up or the usable range ends.
// At most (MAX_BLOCKS+31)/32 words are read, which is 32 at the default size. A free
// reads its word in the idle state and writes it back in the free state. An out-of-range
// free, or an allocate with no usable blocks, goes straight to the result state.
// After reset a clearing pass writes every bitmap word to zero, while no request is
// accepted. A waiting result sits in the output register; the next request is accepted
// meanwhile and holds in its last state until it frees.
`default_nettype none

module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bba_req_if.sink                    in_ch,
  bba_rsp_if.source                  out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int UW    = ($clog2(MAX_BLOCKS + 1) > BC_W) ? $clog2(MAX_BLOCKS + 1) : BC_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]         word_r, word_nxt;
  logic [WORD_BITS_W-1:0] bit_r, bit_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [ID_W-1:0]       res_id_r, res_id_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [BC_W-1:0]       block_count_r, block_count_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  in_accept;
  logic                  cfg_write;
  logic [UW-1:0]         bc_ext;
  logic [UW-1:0]         bc_lim;
  logic [UW-1:0]         usable;
  logic [UW-1:0]         in_id_ext;
  logic                  in_in_range;
  logic [UW-1:0]         word_base;
  logic [UW-1:0]         remaining;
  logic [WORD_W-1:0]     word_mask;
  logic [WORD_W-1:0]     free_bits;
  logic                  word_found;
  logic                  word_last;
  logic [WORD_BITS_W-1:0] found_bit;
  logic [UW-1:0]         found_id;
  logic                  slot_free;

  // Bitmap storage, one bit per block, set when the block is used.
  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.granted_id = out_id_r;

  // Register port: writes complete in the access phase, reads return the count.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_BLOCK_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_BLOCK_COUNT) ? CFG_DATA_W'(block_count_r) : '0;
  assign block_count_nxt = cfg_write ? cfg_pwdata[BC_W-1:0] : block_count_r;

  // Usable block count: saturate to the bitmap size, round down to whole bytes.
  assign bc_ext = UW'(block_count_r);
  assign bc_lim = (bc_ext > UW'(MAX_BLOCKS)) ? UW'(MAX_BLOCKS) : bc_ext;
  assign usable = {bc_lim[UW-1:3], 3'b000};

  // Range check of an incoming free.
  assign in_id_ext   = UW'(in_ch.block_id);
  assign in_in_range = (in_id_ext < usable);

  // Search of the word currently returned by the memory.
  assign word_base  = UW'(word_r) << WORD_BITS_W;
  assign remaining  = usable - word_base;
  assign word_last  = (remaining <= UW'(WORD_W));
  assign word_mask  = word_last ?
                      ((WORD_W'(1) << remaining[WORD_BITS_W-1:0]) - WORD_W'(1)) : '1;
  assign free_bits  = ~ram_rdata & (remaining == UW'(WORD_W) ? '1 : word_mask);
  assign word_found = |free_bits;
  assign found_bit  = lowest_set(free_bits);
  assign found_id   = word_base + UW'(found_bit);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_ch.kind == KIND_ALLOC) begin
            state_nxt = (usable == '0) ? S_RESP : S_SCAN;
          end else begin
            state_nxt = in_in_range ? S_FREE : S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (word_found || word_last) begin
          state_nxt = S_RESP;
        end
      end
      S_FREE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Memory controls, result registers and output register.
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = word_r;
    ram_wdata      = '0;
    ram_raddr      = '0;
    clr_addr_nxt   = clr_addr_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_accept) begin
          res_id_nxt = '0;
          if (in_ch.kind == KIND_ALLOC) begin
            word_nxt       = '0;
            res_status_nxt = ST_FULL;
          end else begin
            word_nxt       = in_id_ext[AW+WORD_BITS_W-1:WORD_BITS_W];
            bit_nxt        = in_id_ext[WORD_BITS_W-1:0];
            ram_raddr      = in_id_ext[AW+WORD_BITS_W-1:WORD_BITS_W];
            res_status_nxt = in_in_range ? ST_FREED : ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (word_found) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata | (WORD_W'(1) << found_bit);
          res_status_nxt = ST_ALLOCATED;
          res_id_nxt     = found_id[ID_W-1:0];
        end else if (!word_last) begin
          word_nxt  = word_r + AW'(1);
          ram_raddr = word_r + AW'(1);
        end
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_r);
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
      block_count_r <= BC_RESET;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      out_valid_r   <= out_valid_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bba_checker.sv @@
// Port-level checks of the bitmap block allocator, bound to the top level.
`default_nettype none

module bba_checker import bba_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire status_t         out_status,
  input wire logic [ID_W-1:0] out_granted_id
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose result transaction has not yet been taken.
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_granted_id))
    else $error("result changed while stalled");

  // Every result answers an earlier request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result without a pending request");

  // At most one request in work and one result waiting.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // Only an allocation carries a block id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ALLOCATED |-> out_granted_id == '0)
    else $error("granted id set on a non-allocation result");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_granted_id (out_ch.granted_id)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the bitmap block allocator against a bitmap predictor.
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam int MAX_BLOCKS  = 1024;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_PHASES  = 7;

  // One request transaction and one result transaction.
  typedef struct {
    logic            kind;
    logic [ID_W-1:0] block_id;
  } alloc_req_t;

  typedef struct {
    status_t         status;
    logic [ID_W-1:0] granted_id;
  } alloc_rsp_t;

  // Receiver back-pressure patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_t;

  // Random phases: block count written, request count and share of allocates.
  int phase_blocks    [NUM_PHASES] = '{16, 2047, 40, 1023, 0, 8, 1024};
  int phase_requests  [NUM_PHASES] = '{120, 300, 150, 900, 30, 60, 80};
  int phase_alloc_pct [NUM_PHASES] = '{60, 90, 55, 95, 50, 60, 50};

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bba_req_if in_ch ();
  bba_rsp_if out_ch ();

  bitmap_block_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state: one used flag per block id and the active block count.
  bit              block_used [MAX_BLOCKS];
  logic [BC_W-1:0] cur_block_count = BC_RESET;

  alloc_req_t req_pending [$];
  alloc_rsp_t rsp_expected [$];

  int       errors      = 0;
  int       idle_cycles = 0;
  bit       in_taken    = 1'b0;
  int       send_gap    = 0;
  int       send_burst  = 1;
  rx_mode_t rx_mode     = RX_ALWAYS;
  int       rx_span     = 0;
  int       rx_stall    = 0;

  // Usable block count: saturated at the bitmap size, rounded down to whole bytes.
  function automatic int usable_blocks();
    int n;
    n = cur_block_count;
    if (n > MAX_BLOCKS) begin
      n = MAX_BLOCKS;
    end
    return (n / 8) * 8;
  endfunction

  // Apply one request to the predicted bitmap and return the answer it must give.
  // Lowest free id first is the same as words upward, bits from the LSB up.
  function automatic alloc_rsp_t serve_request(input logic kind, input logic [ID_W-1:0] id);
    alloc_rsp_t r;
    int         lim;
    bit         found;
    lim          = usable_blocks();
    found        = 1'b0;
    r.status     = ST_FULL;
    r.granted_id = '0;
    if (kind == KIND_ALLOC) begin
      for (int b = 0; b < lim && !found; b++) begin
        if (!block_used[b]) begin
          block_used[b] = 1'b1;
          r.status      = ST_ALLOCATED;
          r.granted_id  = ID_W'(b);
          found         = 1'b1;
        end
      end
    end else if (int'(id) < lim) begin
      block_used[id] = 1'b0;
      r.status       = ST_FREED;
    end else begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  // Mostly frees of blocks in use; some of free blocks and some of any id at all.
  function automatic logic [ID_W-1:0] pick_free_id();
    int lim;
    int roll;
    int id;
    bit hit;
    lim  = usable_blocks();
    roll = $urandom_range(99);
    hit  = 1'b0;
    if (lim == 0 || roll < 15) begin
      id = $urandom_range(MAX_BLOCKS - 1);
    end else begin
      id = $urandom_range(lim - 1);
      for (int t = 0; t < 8 && roll >= 40 && !hit; t++) begin
        id  = $urandom_range(lim - 1);
        hit = block_used[id];
      end
    end
    return ID_W'(id);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: records accepted transactions on both channels and checks results.
  always @(posedge clk) begin
    alloc_rsp_t want;
    bit         out_fire;
    if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_taken) begin
        rsp_expected.push_back(serve_request(in_ch.kind, in_ch.block_id));
      end
      if (out_fire) begin
        if (rsp_expected.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding: status %0d id %0d",
                   $time, out_ch.status, out_ch.granted_id);
        end else begin
          want = rsp_expected.pop_front();
          if (out_ch.status !== want.status || out_ch.granted_id !== want.granted_id) begin
            errors++;
            $display("%0t: result mismatch: expected status %0d id %0d, got status %0d id %0d",
                     $time, want.status, want.granted_id, out_ch.status, out_ch.granted_id);
          end
        end
      end

      // Watchdog on cycles without any accepted transaction or register write.
      if (in_taken || out_fire || (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        req_pending.delete(0);
      end
      if (in_ch.valid && !in_taken) begin
        // Hold the offered transaction until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (req_pending.size() > 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= req_pending[0].kind;
        in_ch.block_id <= req_pending[0].block_id;
        send_burst--;
        if (send_burst <= 0) begin
          send_burst = $urandom_range(30, 1);
          send_gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: switches at random between back-pressure patterns.
  always @(negedge clk) begin
    logic rdy;
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_span = $urandom_range(300, 50);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_ALWAYS: rdy = 1'b1;
      RX_RANDOM: rdy = ($urandom_range(9) < 6);
      RX_SPARSE: rdy = (rx_span % 4 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(9) == 0) begin
            rx_stall = $urandom_range(20, 5);
          end
        end
      end
    endcase
    out_ch.ready <= rdy;
  end

  // Add one request to the driver queue, keeping the queue short.
  task automatic queue_request(input logic kind, input logic [ID_W-1:0] id);
    alloc_req_t r;
    while (req_pending.size() >= 2) @(posedge clk);
    r.kind     = kind;
    r.block_id = id;
    req_pending.push_back(r);
  endtask

  // Wait until every request is sent and every result has come back.
  task automatic wait_until_settled();
    while (req_pending.size() != 0 || in_ch.valid || rsp_expected.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_block_count(input logic [BC_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(REG_BLOCK_COUNT));
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cur_block_count = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Main sequence: reset, directed cases, then random phases over several block counts.
  initial begin
    int   roll;
    logic kind;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_ALLOC;
    in_ch.block_id = '0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // Let the bitmap clearing pass finish.
    repeat (40) @(negedge clk);

    // Directed: first fit, refill of a hole, top id, double free.
    queue_request(KIND_ALLOC, 10'h3ff);
    queue_request(KIND_ALLOC, 10'h000);
    queue_request(KIND_ALLOC, 10'h155);
    queue_request(KIND_FREE, 10'd1);
    queue_request(KIND_ALLOC, 10'h2aa);
    queue_request(KIND_FREE, 10'd1023);
    queue_request(KIND_FREE, 10'd0);
    queue_request(KIND_FREE, 10'd0);
    queue_request(KIND_ALLOC, 10'd0);
    wait_until_settled();

    // Directed: zero usable blocks, written as zero and as a count below one byte.
    write_block_count(11'd0);
    queue_request(KIND_ALLOC, 10'd0);
    queue_request(KIND_FREE, 10'd0);
    queue_request(KIND_FREE, 10'd1023);
    wait_until_settled();
    write_block_count(11'd7);
    queue_request(KIND_ALLOC, 10'd0);
    queue_request(KIND_FREE, 10'd5);
    wait_until_settled();

    // Directed: one byte, filled to full, freed at its edge and just past it.
    write_block_count(11'd8);
    repeat (6) queue_request(KIND_ALLOC, 10'd0);
    queue_request(KIND_FREE, 10'd7);
    queue_request(KIND_FREE, 10'd8);
    queue_request(KIND_ALLOC, 10'd0);
    wait_until_settled();

    // Random phases, with an occasional full drain in the middle of a phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_block_count(BC_W'(phase_blocks[p]));
      for (int n = 0; n < phase_requests[p]; n++) begin
        if ($urandom_range(149) == 0) begin
          wait_until_settled();
        end
        roll = $urandom_range(99);
        kind = (roll < phase_alloc_pct[p]) ? KIND_ALLOC : KIND_FREE;
        if (kind == KIND_ALLOC) begin
          queue_request(KIND_ALLOC, ID_W'($urandom_range(MAX_BLOCKS - 1)));
        end else begin
          queue_request(KIND_FREE, pick_free_id());
        end
      end
      wait_until_settled();
    end

    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
